// File: src/cls_pkg.sv
`default_nettype none

package cls_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_INSTR = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_ADDR  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CLOCKS_PER_US   = 3'd0,
        CFG_STROBE_CYCLE_US = 3'd1,
        CFG_FUNCTION_SET    = 3'd2,
        CFG_DISPLAY_CONTROL = 3'd3,
        CFG_ENTRY_MODE      = 3'd4
    } cfg_idx_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int WAIT_W      = 15;
    localparam int PC_W        = 4;

    localparam logic [7:0] FUNCTION_SET_RST    = 8'h28;
    localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0E;
    localparam logic [7:0] ENTRY_MODE_RST      = 8'h06;
    localparam logic [7:0] CLEAR_BYTE          = 8'h01;
    localparam logic [7:0] ADDR_FLAG           = 8'h80;

    // Program entry points
    localparam logic [PC_W-1:0] PC_INIT = 4'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 4'd12;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
    } req_beat_t;

    typedef struct packed {
        logic              register_select;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] wait_before_us;
        logic              last;
    } xfer_beat_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HIGH  = 2'd1,
        NS_LOW   = 2'd2
    } nib_src_t;

    typedef enum logic [2:0] {
        BS_FUNCTION = 3'd0,
        BS_DISPLAY  = 3'd1,
        BS_CLEAR    = 3'd2,
        BS_ENTRY    = 3'd3,
        BS_HELD     = 3'd4
    } byte_src_t;

    typedef enum logic [2:0] {
        W_NONE  = 3'd0,
        W_50    = 3'd1,
        W_300   = 3'd2,
        W_5000  = 3'd3,
        W_20000 = 3'd4
    } wait_code_t;

    typedef struct packed {
        nib_src_t   nib_src;
        byte_src_t  byte_src;
        logic [3:0] const_nib;
        wait_code_t wait_code;
        logic       last;
    } ctrl_word_t;

    function automatic logic [WAIT_W-1:0] wait_us(input wait_code_t code);
        logic [WAIT_W-1:0] us;
        case (code)
            W_50:    us = 15'd50;
            W_300:   us = 15'd300;
            W_5000:  us = 15'd5000;
            W_20000: us = 15'd20000;
            default: us = 15'd0;
        endcase
        return us;
    endfunction

    function automatic ctrl_word_t mk(input nib_src_t ns, input byte_src_t bs,
                                      input logic [3:0] cn, input wait_code_t wc,
                                      input logic lst);
        ctrl_word_t w;
        w.nib_src   = ns;
        w.byte_src  = bs;
        w.const_nib = cn;
        w.wait_code = wc;
        w.last      = lst;
        return w;
    endfunction

    // Microcode store: init program at PC_INIT, byte program at PC_BYTE
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            4'd0:    w = mk(NS_CONST, BS_HELD,     4'h3, W_20000, 1'b0);
            4'd1:    w = mk(NS_CONST, BS_HELD,     4'h3, W_5000,  1'b0);
            4'd2:    w = mk(NS_CONST, BS_HELD,     4'h3, W_300,   1'b0);
            4'd3:    w = mk(NS_CONST, BS_HELD,     4'h2, W_50,    1'b0);
            4'd4:    w = mk(NS_HIGH,  BS_FUNCTION, 4'h0, W_50,    1'b0);
            4'd5:    w = mk(NS_LOW,   BS_FUNCTION, 4'h0, W_NONE,  1'b0);
            4'd6:    w = mk(NS_HIGH,  BS_DISPLAY,  4'h0, W_50,    1'b0);
            4'd7:    w = mk(NS_LOW,   BS_DISPLAY,  4'h0, W_NONE,  1'b0);
            4'd8:    w = mk(NS_HIGH,  BS_CLEAR,    4'h0, W_50,    1'b0);
            4'd9:    w = mk(NS_LOW,   BS_CLEAR,    4'h0, W_NONE,  1'b0);
            4'd10:   w = mk(NS_HIGH,  BS_ENTRY,    4'h0, W_50,    1'b0);
            4'd11:   w = mk(NS_LOW,   BS_ENTRY,    4'h0, W_NONE,  1'b1);
            4'd12:   w = mk(NS_HIGH,  BS_HELD,     4'h0, W_NONE,  1'b0);
            4'd13:   w = mk(NS_LOW,   BS_HELD,     4'h0, W_NONE,  1'b1);
            default: w = mk(NS_CONST, BS_HELD,     4'h0, W_NONE,  1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: src/char_lcd_4bit_sequencer.sv
// A taken request sets state and step counter; its first beat then enters the output register.
// Throughput: one nibble beat per cycle while the consumer takes them; init gives 12 beats,
// every byte request 2 beats. The microcode step counter sets this: one step per beat.
// A new request is taken once the last beat of the previous one sits in the output register.
// Reset (rst_n low, asynchronous): sequencer idle, no beat pending, init bytes at their
// datasheet defaults.
`default_nettype none

module char_lcd_4bit_sequencer
    import cls_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request channel
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire req_beat_t              req,
    // nibble transfer channel
    output logic                        xfer_valid,
    input  wire logic                   xfer_ready,
    output xfer_beat_t                  xfer,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Sequencer control
    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            xfer_valid_reg, xfer_valid_next;

    // Datapath
    logic [7:0]      held_byte_reg, held_byte_next;
    logic            held_select_reg, held_select_next;
    xfer_beat_t      xfer_reg, xfer_next;

    // Init bytes; clock rate and strobe period only pace the back end, so
    // writes to those indexes are taken and dropped here.
    logic [7:0]      fn_word_reg, disp_word_reg, entry_word_reg;

    ctrl_word_t      cw;
    logic [7:0]      sel_byte;
    logic            req_fire;
    logic            load_out;

    assign cfg_ready  = 1'b1;
    assign req_ready  = (state_reg == SEQ_IDLE);
    assign xfer_valid = xfer_valid_reg;
    assign xfer       = xfer_reg;
    assign req_fire   = req_valid && req_ready;

    // Config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_word_reg    <= FUNCTION_SET_RST;
            disp_word_reg  <= DISPLAY_CONTROL_RST;
            entry_word_reg <= ENTRY_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FUNCTION_SET:    fn_word_reg    <= cfg_data[7:0];
                CFG_DISPLAY_CONTROL: disp_word_reg  <= cfg_data[7:0];
                CFG_ENTRY_MODE:      entry_word_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            pc_reg         <= PC_INIT;
            xfer_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            xfer_valid_reg <= xfer_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_byte_reg   <= held_byte_next;
        held_select_reg <= held_select_next;
        xfer_reg        <= xfer_next;
    end

    // Fetch the control word and steer the byte the step works on
    always_comb
    begin
        cw = rom_word(pc_reg);
        case (cw.byte_src)
            BS_FUNCTION: sel_byte = fn_word_reg;
            BS_DISPLAY:  sel_byte = disp_word_reg;
            BS_CLEAR:    sel_byte = CLEAR_BYTE;
            BS_ENTRY:    sel_byte = entry_word_reg;
            default:     sel_byte = held_byte_reg;
        endcase
    end

    // Next state, step counter and output beat
    always_comb
    begin
        state_next       = state_reg;
        pc_next          = pc_reg;
        held_byte_next   = held_byte_reg;
        held_select_next = held_select_reg;
        xfer_next        = xfer_reg;
        xfer_valid_next  = xfer_valid_reg;
        load_out         = 1'b0;

        // drop the pending beat once the consumer takes it
        if (xfer_valid_reg && xfer_ready)
        begin
            xfer_valid_next = 1'b0;
        end

        case (state_reg)
            SEQ_IDLE:
            begin
                if (req_fire)
                begin
                    // latch the byte and RS level, jump to the program entry
                    state_next       = SEQ_RUN;
                    held_select_next = (req.command == CMD_DATA);
                    held_byte_next   = (req.command == CMD_ADDR) ? (req.value | ADDR_FLAG)
                                                                : req.value;
                    pc_next          = (req.command == CMD_INIT) ? PC_INIT : PC_BYTE;
                end
            end
            SEQ_RUN:
            begin
                // advance only when the output register is free or draining
                load_out = !xfer_valid_reg || xfer_ready;
                if (load_out)
                begin
                    xfer_valid_next = 1'b1;
                    case (cw.nib_src)
                        NS_HIGH: xfer_next.nibble = sel_byte[7:4];
                        NS_LOW:  xfer_next.nibble = sel_byte[3:0];
                        default: xfer_next.nibble = cw.const_nib;
                    endcase
                    xfer_next.register_select = (cw.byte_src == BS_HELD) && held_select_reg;
                    xfer_next.wait_before_us  = wait_us(cw.wait_code);
                    xfer_next.last            = cw.last;
                    if (cw.last)
                    begin
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        pc_next = pc_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/cls_checker.sv
`default_nettype none

module cls_checker
    import cls_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic                   xfer_valid,
    input wire logic                   xfer_ready,
    input wire xfer_beat_t             xfer
);

    // a taken request keeps the channel closed while its beats are produced
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request channel open right after a request beat");

    // a beat that is not the last of its request means the request is still running
    a_mid_request_closed: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && !xfer.last |-> !req_ready)
        else $error("request taken before the previous one finished");

    // only init nibbles carry a wait, and init runs with RS low
    a_wait_is_instr: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && (xfer.wait_before_us != 15'd0) |-> !xfer.register_select)
        else $error("data beat carries a wait");

    // stalled beat holds
    a_xfer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && !xfer_ready |=> xfer_valid && $stable(xfer))
        else $error("stalled transfer beat changed or dropped");

endmodule

bind char_lcd_4bit_sequencer cls_checker u_cls_checker (.*);

`default_nettype wire
